>>> hw/rtl/kmc_pkg.sv
package kmc_pkg;

   localparam int COORD_BITS_DEF   = 16;
   localparam int MAX_POINTS_DEF   = 1024;
   localparam int MAX_CLUSTERS_DEF = 8;

   localparam int MODE_W   = 3;
   localparam int PN_W     = 10;
   localparam int SLOT_W   = 3;
   localparam int LABEL_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int CCOUNT_W = 4;
   localparam int ITER_W   = 8;

   localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 4'd2;
   localparam logic [ITER_W-1:0]   ITER_RESET   = 8'd100;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SEED   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RUN    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LABEL  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_CLUSTER_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ITERATION_LIMIT = 2'd1;

   localparam logic KIND_CENTROID = 1'b0;
   localparam logic KIND_LABEL    = 1'b1;

endpackage

>>> hw/rtl/kmc_if.sv
interface kmc_req_if import kmc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic [MODE_W-1:0]            mode;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic [PN_W-1:0]              point_number;
   logic [SLOT_W-1:0]            seed_slot;

   modport source (output valid, mode, coord_x, coord_y, coord_z, point_number, seed_slot,
                   input ready);
   modport sink (input valid, mode, coord_x, coord_y, coord_z, point_number, seed_slot,
                 output ready);
endinterface

interface kmc_rsp_if import kmc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic                         result_kind;
   logic [LABEL_W-1:0]           cluster_index;
   logic signed [COORD_BITS-1:0] centroid_x;
   logic signed [COORD_BITS-1:0] centroid_y;
   logic signed [COORD_BITS-1:0] centroid_z;
   logic                         last;

   modport source (output valid, result_kind, cluster_index, centroid_x, centroid_y,
                   centroid_z, last, input ready);
   modport sink (input valid, result_kind, cluster_index, centroid_x, centroid_y,
                 centroid_z, last, output ready);
endinterface

interface kmc_csr_if import kmc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/kmc_div.sv
module kmc_div import kmc_pkg::*; #(
   parameter int SUM_W = COORD_BITS_DEF + 11,
   parameter int CNT_W = 11,
   parameter int Q_W   = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]        divisor,
   output logic                    done,
   output logic signed [Q_W-1:0]   quotient
);
   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [CNT_W:0]    trial;
   logic [SUM_W-1:0]  signed_quo;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // One restoring step: bring down a dividend bit and try the subtraction.
         if (trial >= {1'b0, den_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quotient   = signed_quo[Q_W-1:0];
   assign done       = done_ff;
endmodule

>>> hw/rtl/kmc_cell.sv
module kmc_cell import kmc_pkg::*; #(
   parameter int COORD_BITS   = COORD_BITS_DEF,
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
   parameter int CELL_INDEX   = 0,
   localparam int PT_W   = $clog2(MAX_POINTS + 1),
   localparam int AW     = $clog2(MAX_POINTS),
   localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
   localparam int SUM_W  = COORD_BITS + PT_W,
   localparam int DIST_W = 2 * COORD_BITS + 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [AW-1:0]                in_idx,
   input  logic signed [COORD_BITS-1:0] in_px,
   input  logic signed [COORD_BITS-1:0] in_py,
   input  logic signed [COORD_BITS-1:0] in_pz,
   input  logic [DIST_W-1:0]            in_dist,
   input  logic [CL_W-1:0]              in_label,
   output logic                         out_valid,
   output logic [AW-1:0]                out_idx,
   output logic signed [COORD_BITS-1:0] out_px,
   output logic signed [COORD_BITS-1:0] out_py,
   output logic signed [COORD_BITS-1:0] out_pz,
   output logic [DIST_W-1:0]            out_dist,
   output logic [CL_W-1:0]              out_label,
   input  logic                         acc_clear,
   input  logic                         acc_valid,
   input  logic [CL_W-1:0]              acc_label,
   input  logic signed [COORD_BITS-1:0] acc_px,
   input  logic signed [COORD_BITS-1:0] acc_py,
   input  logic signed [COORD_BITS-1:0] acc_pz,
   input  logic [2:0]                   cent_we,
   input  logic signed [COORD_BITS-1:0] cent_wx,
   input  logic signed [COORD_BITS-1:0] cent_wy,
   input  logic signed [COORD_BITS-1:0] cent_wz,
   output logic signed [COORD_BITS-1:0] cent_x,
   output logic signed [COORD_BITS-1:0] cent_y,
   output logic signed [COORD_BITS-1:0] cent_z,
   output logic signed [SUM_W-1:0]      sum_x,
   output logic signed [SUM_W-1:0]      sum_y,
   output logic signed [SUM_W-1:0]      sum_z,
   output logic [PT_W-1:0]              count
);
   localparam int SQ_W = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic signed [COORD_BITS:0]   dx, dy, dz;
   logic signed [SQ_W-1:0]       prod_x, prod_y, prod_z;

   logic                         s1_valid_ff;
   logic [AW-1:0]                s1_idx_ff;
   logic signed [COORD_BITS-1:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic [DIST_W-1:0]            s1_dist_ff;
   logic [CL_W-1:0]              s1_label_ff;
   logic [SQ_W-1:0]              s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;

   logic [DIST_W-1:0]            dist_in;
   logic                         take;

   logic                         s2_valid_ff;
   logic [AW-1:0]                s2_idx_ff;
   logic signed [COORD_BITS-1:0] s2_px_ff, s2_py_ff, s2_pz_ff;
   logic [DIST_W-1:0]            s2_dist_ff;
   logic [CL_W-1:0]              s2_label_ff;

   logic signed [SUM_W-1:0]      sx_ff, sy_ff, sz_ff;
   logic [PT_W-1:0]              cnt_ff;

   assign dx     = (COORD_BITS + 1)'(in_px) - (COORD_BITS + 1)'(cx_ff);
   assign dy     = (COORD_BITS + 1)'(in_py) - (COORD_BITS + 1)'(cy_ff);
   assign dz     = (COORD_BITS + 1)'(in_pz) - (COORD_BITS + 1)'(cz_ff);
   assign prod_x = dx * dx;
   assign prod_y = dy * dy;
   assign prod_z = dz * dz;

   // Strict comparison keeps the lower cluster on a tie.
   assign dist_in = DIST_W'(s1_sqx_ff) + DIST_W'(s1_sqy_ff) + DIST_W'(s1_sqz_ff);
   assign take    = enable && (dist_in < s1_dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_idx_ff   <= in_idx;
      s1_px_ff    <= in_px;
      s1_py_ff    <= in_py;
      s1_pz_ff    <= in_pz;
      s1_dist_ff  <= in_dist;
      s1_label_ff <= in_label;
      s1_sqx_ff   <= unsigned'(prod_x);
      s1_sqy_ff   <= unsigned'(prod_y);
      s1_sqz_ff   <= unsigned'(prod_z);
      s2_idx_ff   <= s1_idx_ff;
      s2_px_ff    <= s1_px_ff;
      s2_py_ff    <= s1_py_ff;
      s2_pz_ff    <= s1_pz_ff;
      s2_dist_ff  <= take ? dist_in : s1_dist_ff;
      s2_label_ff <= take ? CL_W'(CELL_INDEX) : s1_label_ff;
   end

   always_ff @(posedge clock) begin
      if (cent_we[0]) begin
         cx_ff <= cent_wx;
      end
      if (cent_we[1]) begin
         cy_ff <= cent_wy;
      end
      if (cent_we[2]) begin
         cz_ff <= cent_wz;
      end
      if (acc_clear) begin
         sx_ff  <= '0;
         sy_ff  <= '0;
         sz_ff  <= '0;
         cnt_ff <= '0;
      end else if (acc_valid && (acc_label == CL_W'(CELL_INDEX))) begin
         sx_ff  <= sx_ff + SUM_W'(acc_px);
         sy_ff  <= sy_ff + SUM_W'(acc_py);
         sz_ff  <= sz_ff + SUM_W'(acc_pz);
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_idx   = s2_idx_ff;
   assign out_px    = s2_px_ff;
   assign out_py    = s2_py_ff;
   assign out_pz    = s2_pz_ff;
   assign out_dist  = s2_dist_ff;
   assign out_label = s2_label_ff;
   assign cent_x    = cx_ff;
   assign cent_y    = cy_ff;
   assign cent_z    = cz_ff;
   assign sum_x     = sx_ff;
   assign sum_y     = sy_ff;
   assign sum_z     = sz_ff;
   assign count     = cnt_ff;
endmodule

>>> hw/rtl/kmeans_clustering_3d.sv
// Channel | Dir | Carries
// req     | in  | mode, coord_x/y/z, point_number, seed_slot
// rsp     | out | result_kind, cluster_index, centroid_x/y/z, last
// csr     | in  | index, data (cluster_count, iteration_limit)
//
// Clear and append are done in the idle state; seed and label read each pass through a state of their own.
// A run does iteration_limit rounds (none when no points are stored) and then emits K
// results. Each round streams the points through the chain of 2-stage distance cells,
// then one shared bit-serial divider forms each new centroid axis.
// Reset is synchronous and empties the point store; centroids and labels hold garbage
// until seeded or labelled. A stalled rsp holds the emission; req is taken only when idle.
module kmeans_clustering_3d import kmc_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
   parameter int COORD_BITS   = COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   kmc_req_if.sink   req,
   kmc_rsp_if.source rsp,
   kmc_csr_if.sink   csr
);
   localparam int PT_W   = $clog2(MAX_POINTS + 1);
   localparam int AW     = $clog2(MAX_POINTS);
   localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int KW     = $clog2(MAX_CLUSTERS + 1);
   localparam int SUM_W  = COORD_BITS + PT_W;
   localparam int DIST_W = 2 * COORD_BITS + 4;
   localparam int PW     = 3 * COORD_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEED   = 3'd1;
   localparam logic [2:0] ST_LABEL  = 3'd2;
   localparam logic [2:0] ST_ASSIGN = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_DIVIDE = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [PT_W-1:0]     total_ff, total_in;
   logic [CCOUNT_W-1:0] ccount_ff;
   logic [ITER_W-1:0]   limit_ff;
   logic [KW-1:0]       kk_ff, kk_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [PT_W-1:0]     issue_ff, issue_in;
   logic [PT_W-1:0]     done_ff, done_in;
   logic [KW-1:0]       updc_ff, updc_in;
   logic [1:0]          axis_ff, axis_in;
   logic [CL_W-1:0]     emit_ff, emit_in;
   logic [CL_W-1:0]     slot_ff, slot_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [LABEL_W-1:0]           rsp_index_ff, rsp_index_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_free;

   logic [PW-1:0]   pt_mem [MAX_POINTS];
   logic [PW-1:0]   pt_rd_ff;
   logic            pt_we, pt_re;
   logic [AW-1:0]   pt_raddr;
   logic [CL_W-1:0] lb_mem [MAX_POINTS];
   logic [CL_W-1:0] lb_rd_ff;
   logic            lb_re;
   logic [AW-1:0]   pn_addr;
   logic            pn_ok;

   logic            feed_valid_ff, feed_valid_in;
   logic [AW-1:0]   feed_idx_ff;

   logic                         acc_clear, div_start, div_done, last_emit;
   logic signed [SUM_W-1:0]      div_dividend;
   logic [PT_W-1:0]              div_divisor;
   logic signed [COORD_BITS-1:0] div_quo;
   logic [CL_W-1:0]              updc_sel;

   logic                         ch_valid [MAX_CLUSTERS + 1];
   logic [AW-1:0]                ch_idx   [MAX_CLUSTERS + 1];
   logic signed [COORD_BITS-1:0] ch_px    [MAX_CLUSTERS + 1];
   logic signed [COORD_BITS-1:0] ch_py    [MAX_CLUSTERS + 1];
   logic signed [COORD_BITS-1:0] ch_pz    [MAX_CLUSTERS + 1];
   logic [DIST_W-1:0]            ch_dist  [MAX_CLUSTERS + 1];
   logic [CL_W-1:0]              ch_label [MAX_CLUSTERS + 1];

   logic signed [COORD_BITS-1:0] c_x [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] c_y [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] c_z [MAX_CLUSTERS];
   logic signed [SUM_W-1:0]      s_x [MAX_CLUSTERS];
   logic signed [SUM_W-1:0]      s_y [MAX_CLUSTERS];
   logic signed [SUM_W-1:0]      s_z [MAX_CLUSTERS];
   logic [PT_W-1:0]              s_n [MAX_CLUSTERS];
   logic [2:0]                   c_we [MAX_CLUSTERS];
   logic                         c_en [MAX_CLUSTERS];
   logic signed [COORD_BITS-1:0] cw_x, cw_y, cw_z;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign pn_addr   = AW'(32'(req.point_number));
   assign pn_ok     = 32'(req.point_number) < 32'(total_ff);
   assign updc_sel  = updc_ff[CL_W-1:0];
   assign last_emit = (32'(emit_ff) + 1) == 32'(kk_ff);

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      kk_in         = kk_ff;
      iter_in       = iter_ff;
      issue_in      = issue_ff;
      done_in       = done_ff;
      updc_in       = updc_ff;
      axis_in       = axis_ff;
      emit_in       = emit_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_last_in   = rsp_last_ff;
      pt_we         = 1'b0;
      pt_re         = 1'b0;
      pt_raddr      = issue_ff[AW-1:0];
      lb_re         = 1'b0;
      acc_clear     = 1'b0;
      div_start     = 1'b0;
      feed_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               unique case (req.mode)
                  MODE_CLEAR: begin
                     total_in = '0;
                  end
                  MODE_APPEND: begin
                     if (32'(total_ff) < MAX_POINTS) begin
                        pt_we    = 1'b1;
                        total_in = total_ff + 1'b1;
                     end
                  end
                  MODE_SEED: begin
                     if (pn_ok && (32'(req.seed_slot) < MAX_CLUSTERS)) begin
                        pt_re    = 1'b1;
                        pt_raddr = pn_addr;
                        slot_in  = CL_W'(req.seed_slot);
                        state_in = ST_SEED;
                     end
                  end
                  MODE_RUN: begin
                     if (ccount_ff == '0) begin
                        kk_in = KW'(1);
                     end else if (32'(ccount_ff) > MAX_CLUSTERS) begin
                        kk_in = KW'(MAX_CLUSTERS);
                     end else begin
                        kk_in = KW'(ccount_ff);
                     end
                     iter_in = '0;
                     emit_in = '0;
                     if (total_ff == '0 || limit_ff == '0) begin
                        state_in = ST_EMIT;
                     end else begin
                        acc_clear = 1'b1;
                        issue_in  = '0;
                        done_in   = '0;
                        state_in  = ST_ASSIGN;
                     end
                  end
                  MODE_LABEL: begin
                     if (pn_ok) begin
                        lb_re    = 1'b1;
                        state_in = ST_LABEL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEED: begin
            state_in = ST_IDLE;
         end
         ST_LABEL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_LABEL;
               rsp_index_in = LABEL_W'(lb_rd_ff);
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_z_in     = '0;
               rsp_last_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_ASSIGN: begin
            if (issue_ff < total_ff) begin
               pt_re         = 1'b1;
               feed_valid_in = 1'b1;
               issue_in      = issue_ff + 1'b1;
            end
            if (ch_valid[MAX_CLUSTERS]) begin
               done_in = done_ff + 1'b1;
               if (done_ff + 1'b1 == total_ff) begin
                  updc_in  = '0;
                  axis_in  = '0;
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (updc_ff == kk_ff) begin
               iter_in = iter_ff + 1'b1;
               if ({1'b0, iter_ff} + 9'd1 == {1'b0, limit_ff}) begin
                  emit_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  acc_clear = 1'b1;
                  issue_in  = '0;
                  done_in   = '0;
                  state_in  = ST_ASSIGN;
               end
            end else if (s_n[updc_sel] == '0) begin
               // An empty cluster keeps its centroid.
               updc_in = updc_ff + 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (axis_ff == 2'd2) begin
                  axis_in = '0;
                  updc_in = updc_ff + 1'b1;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CENTROID;
               rsp_index_in = LABEL_W'(emit_ff);
               rsp_x_in     = c_x[emit_ff];
               rsp_y_in     = c_y[emit_ff];
               rsp_z_in     = c_z[emit_ff];
               rsp_last_in  = last_emit;
               if (last_emit) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         feed_valid_ff <= 1'b0;
         ccount_ff     <= CCOUNT_RESET;
         limit_ff      <= ITER_RESET;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
         feed_valid_ff <= feed_valid_in;
         if (csr.valid) begin
            unique case (csr.index)
               REG_CLUSTER_COUNT:   ccount_ff <= csr.data[CCOUNT_W-1:0];
               REG_ITERATION_LIMIT: limit_ff  <= csr.data[ITER_W-1:0];
               default: begin
               end
            endcase
         end
      end
      kk_ff        <= kk_in;
      iter_ff      <= iter_in;
      issue_ff     <= issue_in;
      done_ff      <= done_in;
      updc_ff      <= updc_in;
      axis_ff      <= axis_in;
      emit_ff      <= emit_in;
      slot_ff      <= slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_last_ff  <= rsp_last_in;
      feed_idx_ff  <= issue_ff[AW-1:0];
   end

   // Point and label stores.
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[total_ff[AW-1:0]] <= {req.coord_x, req.coord_y, req.coord_z};
      end
      if (pt_re) begin
         pt_rd_ff <= pt_mem[pt_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ch_valid[MAX_CLUSTERS]) begin
         lb_mem[ch_idx[MAX_CLUSTERS]] <= ch_label[MAX_CLUSTERS];
      end
      if (lb_re) begin
         lb_rd_ff <= lb_mem[pn_addr];
      end
   end

   assign ch_valid[0] = feed_valid_ff;
   assign ch_idx[0]   = feed_idx_ff;
   assign ch_px[0]    = pt_rd_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign ch_py[0]    = pt_rd_ff[2*COORD_BITS-1:COORD_BITS];
   assign ch_pz[0]    = pt_rd_ff[COORD_BITS-1:0];
   assign ch_dist[0]  = '1;
   assign ch_label[0] = '0;

   // A seed loads all three axes from the store; a divide result loads one axis.
   always_comb begin
      if (state_ff == ST_SEED) begin
         cw_x = ch_px[0];
         cw_y = ch_py[0];
         cw_z = ch_pz[0];
      end else begin
         cw_x = div_quo;
         cw_y = div_quo;
         cw_z = div_quo;
      end
   end

   always_comb begin
      case (axis_ff)
         2'd0:    div_dividend = s_x[updc_sel];
         2'd1:    div_dividend = s_y[updc_sel];
         default: div_dividend = s_z[updc_sel];
      endcase
      div_divisor = s_n[updc_sel];
   end

   for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
      assign c_en[g] = KW'(g) < kk_ff;
      always_comb begin
         c_we[g] = 3'b000;
         if (state_ff == ST_SEED && slot_ff == CL_W'(g)) begin
            c_we[g] = 3'b111;
         end else if (state_ff == ST_DIVIDE && div_done && updc_ff == KW'(g)) begin
            c_we[g] = 3'b001 << axis_ff;
         end
      end

      kmc_cell #(
         .COORD_BITS   (COORD_BITS),
         .MAX_POINTS   (MAX_POINTS),
         .MAX_CLUSTERS (MAX_CLUSTERS),
         .CELL_INDEX   (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (c_en[g]),
         .in_valid  (ch_valid[g]),
         .in_idx    (ch_idx[g]),
         .in_px     (ch_px[g]),
         .in_py     (ch_py[g]),
         .in_pz     (ch_pz[g]),
         .in_dist   (ch_dist[g]),
         .in_label  (ch_label[g]),
         .out_valid (ch_valid[g+1]),
         .out_idx   (ch_idx[g+1]),
         .out_px    (ch_px[g+1]),
         .out_py    (ch_py[g+1]),
         .out_pz    (ch_pz[g+1]),
         .out_dist  (ch_dist[g+1]),
         .out_label (ch_label[g+1]),
         .acc_clear (acc_clear),
         .acc_valid (ch_valid[MAX_CLUSTERS]),
         .acc_label (ch_label[MAX_CLUSTERS]),
         .acc_px    (ch_px[MAX_CLUSTERS]),
         .acc_py    (ch_py[MAX_CLUSTERS]),
         .acc_pz    (ch_pz[MAX_CLUSTERS]),
         .cent_we   (c_we[g]),
         .cent_wx   (cw_x),
         .cent_wy   (cw_y),
         .cent_wz   (cw_z),
         .cent_x    (c_x[g]),
         .cent_y    (c_y[g]),
         .cent_z    (c_z[g]),
         .sum_x     (s_x[g]),
         .sum_y     (s_y[g]),
         .sum_z     (s_z[g]),
         .count     (s_n[g])
      );
   end

   kmc_div #(
      .SUM_W (SUM_W),
      .CNT_W (PT_W),
      .Q_W   (COORD_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.result_kind   = rsp_kind_ff;
   assign rsp.cluster_index = rsp_index_ff;
   assign rsp.centroid_x    = rsp_x_ff;
   assign rsp.centroid_y    = rsp_y_ff;
   assign rsp.centroid_z    = rsp_z_ff;
   assign rsp.last          = rsp_last_ff;
endmodule

>>> hw/rtl/kmc_checker.sv
module kmc_checker import kmc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_result_kind,
   input logic [LABEL_W-1:0]           rsp_cluster_index,
   input logic signed [COORD_BITS-1:0] rsp_centroid_x,
   input logic signed [COORD_BITS-1:0] rsp_centroid_y,
   input logic signed [COORD_BITS-1:0] rsp_centroid_z,
   input logic                         rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cluster_index)
         && $stable(rsp_centroid_x) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_label_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_LABEL |-> rsp_centroid_x == '0
         && rsp_centroid_y == '0 && rsp_centroid_z == '0 && !rsp_last)
      else $error("label result carries centroid data");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_CENTROID && !rsp_last |-> !req_ready)
      else $error("request taken while a run is still emitting");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");
endmodule

bind kmeans_clustering_3d kmc_checker #(.COORD_BITS(COORD_BITS)) u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_result_kind   (rsp.result_kind),
   .rsp_cluster_index (rsp.cluster_index),
   .rsp_centroid_x    (rsp.centroid_x),
   .rsp_centroid_y    (rsp.centroid_y),
   .rsp_centroid_z    (rsp.centroid_z),
   .rsp_last          (rsp.last)
);
